// ----- design/iiac_pkg.sv -----
// iiac_pkg: shared types and constants for the ip-id interleave alias check
// used by iiac_pair_check and ipid_interleave_alias_check_core
// no dependencies

package iiac_pkg;

  localparam int unsigned IdentW   = 16;
  localparam int unsigned TokenW   = 32;
  localparam int unsigned CountW   = 2;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // top of the ip-id counter range used in the rollover gap
  localparam logic [IdentW-1:0] RollTop = 16'hFFFF;

  localparam logic [IdentW-1:0] MaxDiffReset = 16'd200;

  // register indices (byte address / 4)
  localparam logic [PaddrW-3:0] RegMaxDiff = 1'b0;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED    = 2'd0,
    VERDICT_REJECTED    = 2'd1,
    VERDICT_NO_SEQUENCE = 2'd2
  } verdict_e;

  // outcome of one ordered (earlier, later) ip-id check
  typedef struct packed {
    logic roll;  // counted as a rollover
    logic rej;   // gap too large, pair rejected
  } pair_res_t;

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] cnt,
                                               input logic [CountW-1:0] inc);
    logic [CountW:0] sum;
    sum = {1'b0, cnt} + {1'b0, inc};
    return sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];
  endfunction

endpackage

// ----- design/iiac_pair_check.sv -----
// iiac_pair_check: checks one ordered pair of ip-ids for order or rollover
// depends on iiac_pkg

module iiac_pair_check (
  input  logic [iiac_pkg::IdentW-1:0] earlier_i,
  input  logic [iiac_pkg::IdentW-1:0] later_i,
  input  logic [iiac_pkg::IdentW-1:0] max_diff_i,
  output iiac_pkg::pair_res_t         res_o
);

  logic                      out_of_order;
  logic [iiac_pkg::IdentW:0] gap;

  assign out_of_order = earlier_i > later_i;
  // wrap gap across the top of the counter
  assign gap = {1'b0, iiac_pkg::RollTop - earlier_i} + {1'b0, later_i};

  assign res_o.rej  = out_of_order && (gap > {1'b0, max_diff_i});
  assign res_o.roll = out_of_order && !(gap > {1'b0, max_diff_i});

endmodule

// ----- design/ipid_interleave_alias_check_core.sv -----
// ipid_interleave_alias_check_core: top level of the ip-id alias checker
// depends on iiac_pkg and iiac_pair_check
// flow: a round is evaluated while it sits in the input register; its verdict
//   (last round only) then goes into the result register when that can take it
// throughput: one round per cycle unless a last round waits on the result register;
//   the evaluation stage between the two does one subtract and compare per pair check
// reset: pair state and counters cleared, max_diff back to 200, no verdict

module ipid_interleave_alias_check_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [iiac_pkg::PaddrW-1:0] paddr_i,
  input  logic [iiac_pkg::PdataW-1:0] pwdata_i,
  output logic [iiac_pkg::PdataW-1:0] prdata_o,
  output logic                        pready_o,
  // probe round channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        first_round_i,
  input  logic                        last_round_i,
  input  logic                        has_data_a_i,
  input  logic                        has_data_b_i,
  input  logic [iiac_pkg::TokenW-1:0] token_a_i,
  input  logic [iiac_pkg::TokenW-1:0] token_b_i,
  input  logic [iiac_pkg::IdentW-1:0] ident_a_i,
  input  logic [iiac_pkg::IdentW-1:0] ident_b_i,
  // verdict channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  verdict_o
);

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic [iiac_pkg::IdentW-1:0]   max_diff_q;
  logic                          cfg_wr;
  logic                          cfg_hit;

  assign pready_o = 1'b1;
  assign cfg_hit  = paddr_i[iiac_pkg::PaddrW-1:2] == iiac_pkg::RegMaxDiff;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q <= iiac_pkg::MaxDiffReset;
    end else if (cfg_wr) begin
      max_diff_q <= pwdata_i[iiac_pkg::IdentW-1:0];
    end
  end

  // reads of unmapped addresses return zero
  always_comb begin
    prdata_o = '0;
    if (cfg_hit) begin
      prdata_o = {{(iiac_pkg::PdataW - iiac_pkg::IdentW){1'b0}}, max_diff_q};
    end
  end

  // ---------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------
  logic                        stg_valid_q;
  logic                        stg_first_q;
  logic                        stg_last_q;
  logic                        stg_has_a_q;
  logic                        stg_has_b_q;
  logic                        stg_a_first_q;  // token order, resolved early
  logic [iiac_pkg::IdentW-1:0] stg_id_a_q;
  logic [iiac_pkg::IdentW-1:0] stg_id_b_q;

  logic in_fire;
  logic stg_fire;
  logic out_load_ok;

  // result register can take a verdict when empty or being drained
  assign out_load_ok = !out_valid_o || out_ready_i;
  // rounds that give no verdict retire regardless of the output side
  assign stg_fire    = stg_valid_q && (!stg_last_q || out_load_ok);
  assign in_ready_o  = !stg_valid_q || stg_fire;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_first_q   <= first_round_i;
      stg_last_q    <= last_round_i;
      stg_has_a_q   <= has_data_a_i;
      stg_has_b_q   <= has_data_b_i;
      // equal tokens count as b probed first
      stg_a_first_q <= token_a_i < token_b_i;
      stg_id_a_q    <= ident_a_i;
      stg_id_b_q    <= ident_b_i;
    end
  end

  // ---------------------------------------------------------------------
  // pair state
  // ---------------------------------------------------------------------
  logic [iiac_pkg::IdentW-1:0] prev_ident_a_q, prev_ident_a_d;
  logic [iiac_pkg::IdentW-1:0] prev_ident_b_q, prev_ident_b_d;
  logic [iiac_pkg::CountW-1:0] order_rollovers_q, order_rollovers_d;
  logic [iiac_pkg::CountW-1:0] cross_rollovers_q, cross_rollovers_d;
  logic                        rejected_flag_q, rejected_flag_d;
  logic                        data_present_q, data_present_d;

  // ---------------------------------------------------------------------
  // evaluation: pass one (within round) and pass two (crosswise)
  // ---------------------------------------------------------------------
  logic [iiac_pkg::IdentW-1:0] ord_earlier;
  logic [iiac_pkg::IdentW-1:0] ord_later;
  iiac_pkg::pair_res_t         ord_res;
  iiac_pkg::pair_res_t         cross_ab_res;  // prev a against this b
  iiac_pkg::pair_res_t         cross_ba_res;  // prev b against this a

  assign ord_earlier = stg_a_first_q ? stg_id_a_q : stg_id_b_q;
  assign ord_later   = stg_a_first_q ? stg_id_b_q : stg_id_a_q;

  iiac_pair_check u_ord_check (
    .earlier_i  (ord_earlier),
    .later_i    (ord_later),
    .max_diff_i (max_diff_q),
    .res_o      (ord_res)
  );

  iiac_pair_check u_cross_ab_check (
    .earlier_i  (prev_ident_a_q),
    .later_i    (stg_id_b_q),
    .max_diff_i (max_diff_q),
    .res_o      (cross_ab_res)
  );

  iiac_pair_check u_cross_ba_check (
    .earlier_i  (prev_ident_b_q),
    .later_i    (stg_id_a_q),
    .max_diff_i (max_diff_q),
    .res_o      (cross_ba_res)
  );

  logic [iiac_pkg::CountW-1:0] order_base;
  logic [iiac_pkg::CountW-1:0] cross_base;
  logic [iiac_pkg::CountW-1:0] cross_inc;
  logic                        rej_base;
  logic                        cross_on;
  iiac_pkg::verdict_e          verdict;

  always_comb begin
    // a first round starts a fresh pair
    order_base = stg_first_q ? '0 : order_rollovers_q;
    cross_base = stg_first_q ? '0 : cross_rollovers_q;
    rej_base   = stg_first_q ? 1'b0 : rejected_flag_q;
    // no previous round to cross-check against on a first round
    cross_on   = !stg_first_q;
    cross_inc  = {1'b0, cross_ab_res.roll} + {1'b0, cross_ba_res.roll};

    data_present_d    = stg_first_q ? (stg_has_a_q && stg_has_b_q) : data_present_q;
    order_rollovers_d = iiac_pkg::sat_add(order_base, {1'b0, ord_res.roll});
    cross_rollovers_d = cross_on ? iiac_pkg::sat_add(cross_base, cross_inc)
                                 : cross_base;

    rejected_flag_d = rej_base
                   || ord_res.rej
                   || (order_rollovers_d > 2'd1)
                   || (cross_on && (cross_ab_res.rej || cross_ba_res.rej))
                   || (cross_on && (cross_rollovers_d > 2'd2));

    prev_ident_a_d = stg_id_a_q;
    prev_ident_b_d = stg_id_b_q;

    if (!data_present_d) begin
      verdict = iiac_pkg::VERDICT_NO_SEQUENCE;
    end else if (rejected_flag_d) begin
      verdict = iiac_pkg::VERDICT_REJECTED;
    end else begin
      verdict = iiac_pkg::VERDICT_ACCEPTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ident_a_q    <= '0;
      prev_ident_b_q    <= '0;
      order_rollovers_q <= '0;
      cross_rollovers_q <= '0;
      rejected_flag_q   <= 1'b0;
      data_present_q    <= 1'b0;
    end else if (stg_fire) begin
      prev_ident_a_q    <= prev_ident_a_d;
      prev_ident_b_q    <= prev_ident_b_d;
      order_rollovers_q <= order_rollovers_d;
      cross_rollovers_q <= cross_rollovers_d;
      rejected_flag_q   <= rejected_flag_d;
      data_present_q    <= data_present_d;
    end
  end

  // ---------------------------------------------------------------------
  // result register: verdict transaction on the last round
  // ---------------------------------------------------------------------
  logic       out_valid_q;
  logic [1:0] verdict_q;
  logic       out_load;

  assign out_load = stg_fire && stg_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule
